/* src/cpp_pkg.sv */
// ----------------------------------------------------------------------------
// cpp_pkg: shared types and constants of the constant-power pan gain block
// Gain formats, register indexes and the sideband that rides with each word.
// ----------------------------------------------------------------------------
package cpp_pkg;

  localparam logic [15:0] UNITY_Q15 = 16'd32768;
  localparam logic [15:0] HALF_Q15  = 16'd16384;

  // register indexes of the configuration port
  typedef enum logic [1:0] {
    CFG_DEST_COUNT = 2'd0,
    CFG_CENTER     = 2'd1,
    CFG_LFE        = 2'd2
  } cfg_idx_e;

  // sideband carried through the gain square-root pipeline
  typedef struct packed {
    logic [2:0]  src;
    logic [15:0] tri_w;   // 1 - |2 pan - 1|, unsigned Q1.15
  } gain_side_t;

endpackage

/* src/cpp_gain_sqrt.sv */
// ----------------------------------------------------------------------------
// cpp_gain_sqrt: left and right gain square roots
// Two 16-step root lanes, one bit per stage, with round-half-up at the end.
// ----------------------------------------------------------------------------
module cpp_gain_sqrt
  import cpp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic [15:0] pan_i,
  input  gain_side_t  side_i,
  output logic        valid_o,
  output logic [15:0] left_o,
  output logic [15:0] right_o,
  output gain_side_t  side_o
);

  logic        v_q    [0:16];
  gain_side_t  side_q [0:16];
  logic [31:0] ln_q   [0:16];
  logic [31:0] rn_q   [0:16];
  logic [16:0] lrem_q [0:16];
  logic [16:0] rrem_q [0:16];
  logic [15:0] lrt_q  [0:16];
  logic [15:0] rrt_q  [0:16];
  logic [15:0] lrad;

  assign lrad = 16'(UNITY_Q15 - pan_i);

  assign v_q[0]    = valid_i;
  assign side_q[0] = side_i;
  assign ln_q[0]   = {1'b0, lrad, 15'd0};
  assign rn_q[0]   = {1'b0, pan_i, 15'd0};
  assign lrem_q[0] = '0;
  assign rrem_q[0] = '0;
  assign lrt_q[0]  = '0;
  assign rrt_q[0]  = '0;

  for (genvar k = 0; k < 16; k++) begin : g_step
    logic [18:0] lext, rext, ltrial, rtrial;
    logic        lfit, rfit;

    always_comb begin
      lext   = {lrem_q[k], ln_q[k][31:30]};
      rext   = {rrem_q[k], rn_q[k][31:30]};
      ltrial = {1'b0, lrt_q[k], 2'b01};
      rtrial = {1'b0, rrt_q[k], 2'b01};
      lfit   = lext >= ltrial;
      rfit   = rext >= rtrial;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      side_q[k+1] <= side_q[k];
      ln_q[k+1]   <= {ln_q[k][29:0], 2'b00};
      rn_q[k+1]   <= {rn_q[k][29:0], 2'b00};
      lrem_q[k+1] <= lfit ? 17'(lext - ltrial) : lext[16:0];
      rrem_q[k+1] <= rfit ? 17'(rext - rtrial) : rext[16:0];
      lrt_q[k+1]  <= {lrt_q[k][14:0], lfit};
      rrt_q[k+1]  <= {rrt_q[k][14:0], rfit};
    end
  end

  logic        valid_q;
  logic [15:0] left_q, right_q;
  gain_side_t  side_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= v_q[16];
    end
  end

  // round half up: remainder above the root means the next integer is closer
  always_ff @(posedge clk_i) begin
    left_q     <= (lrem_q[16] > {1'b0, lrt_q[16]}) ? lrt_q[16] + 16'd1 : lrt_q[16];
    right_q    <= (rrem_q[16] > {1'b0, rrt_q[16]}) ? rrt_q[16] + 16'd1 : rrt_q[16];
    side_out_q <= side_q[16];
  end

  assign valid_o = valid_q;
  assign left_o  = left_q;
  assign right_o = right_q;
  assign side_o  = side_out_q;

endmodule

/* src/constant_power_pan_gains_top.sv */
// ----------------------------------------------------------------------------
// constant_power_pan_gains_top: constant-power pan gain generator
// Turns one source channel and listener geometry into four mix gains.
// ----------------------------------------------------------------------------
// Usage:
//   Drive the source fields and raise start for one cycle per word. busy is
//   always low, so a new word can be taken on every clock.
//   Each result word shows up on the gain ports for exactly one cycle
//   with valid_o high.
//   Throughput is one word per cycle: projection, squares, a 32-step root,
//   a 15-step divider and two 16-step gain roots are all fully pipelined,
//   one bit per stage.
//   Configuration registers are written through cfg_we_i / cfg_idx_i /
//   cfg_data_i and should only change while no word is in flight; they are
//   applied at the output stage.
//   Reset clears all valid bits and loads the registers with two destination
//   channels and zero center and LFE levels. The receiver cannot stall, so
//   every result must be captured in its valid cycle.
// ----------------------------------------------------------------------------
module constant_power_pan_gains_top
  import cpp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  input  logic [2:0]         src_channel_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic signed [15:0] fwd_ax_i,
  input  logic signed [15:0] fwd_ay_i,
  input  logic signed [15:0] fwd_az_i,
  input  logic signed [15:0] side_ax_i,
  input  logic signed [15:0] side_ay_i,
  input  logic signed [15:0] side_az_i,
  output logic               valid_o,
  output logic [15:0]        left_gain_o,
  output logic [15:0]        right_gain_o,
  output logic [15:0]        mid_gain_o,
  output logic [15:0]        sub_gain_o
);

  assign busy = 1'b0;

  // ---------------- configuration ----------------
  logic [3:0]  dest_q;
  logic [15:0] center_q, lfe_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dest_q   <= 4'd2;
      center_q <= '0;
      lfe_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_DEST_COUNT: dest_q   <= cfg_data_i[3:0];
        CFG_CENTER:     center_q <= cfg_data_i;
        CFG_LFE:        lfe_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------- stage 1: products ----------------
  logic               s1_v_q;
  logic [2:0]         s1_src_q;
  logic signed [47:0] s1_p_q [6];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else begin
      s1_v_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_src_q  <= src_channel_i;
    s1_p_q[0] <= pos_x_i * fwd_ax_i;
    s1_p_q[1] <= pos_y_i * fwd_ay_i;
    s1_p_q[2] <= pos_z_i * fwd_az_i;
    s1_p_q[3] <= pos_x_i * side_ax_i;
    s1_p_q[4] <= pos_y_i * side_ay_i;
    s1_p_q[5] <= pos_z_i * side_az_i;
  end

  // ---------------- stage 2: sum, floor shift, saturate ----------------
  function automatic logic signed [31:0] sat_proj(input logic signed [47:0] a,
                                                  input logic signed [47:0] b,
                                                  input logic signed [47:0] c);
    logic signed [49:0] sum;
    logic signed [35:0] sh;
    begin
      sum = 50'(a) + 50'(b) + 50'(c);
      sh  = 36'(sum >>> 14);
      if (sh > 36'sd2147483647)       sat_proj = 32'sh7FFF_FFFF;
      else if (sh < -36'sd2147483648) sat_proj = 32'sh8000_0000;
      else                            sat_proj = sh[31:0];
    end
  endfunction

  logic signed [31:0] x_w, y_w;
  logic               s2_v_q, s2_ys_q;
  logic [2:0]         s2_src_q;
  logic [31:0]        s2_ux_q, s2_uy_q;

  assign x_w = sat_proj(s1_p_q[0], s1_p_q[1], s1_p_q[2]);
  assign y_w = sat_proj(s1_p_q[3], s1_p_q[4], s1_p_q[5]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_src_q <= s1_src_q;
    s2_ys_q  <= y_w[31];
    s2_ux_q  <= x_w[31] ? 32'(-x_w) : 32'(x_w);
    s2_uy_q  <= y_w[31] ? 32'(-y_w) : 32'(y_w);
  end

  // ---------------- stage 3: squares ----------------
  logic        s3_v_q, s3_ys_q;
  logic [2:0]  s3_src_q;
  logic [31:0] s3_uy_q;
  logic [63:0] s3_xx_q, s3_yy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else begin
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_src_q <= s2_src_q;
    s3_ys_q  <= s2_ys_q;
    s3_uy_q  <= s2_uy_q;
    s3_xx_q  <= s2_ux_q * s2_ux_q;
    s3_yy_q  <= s2_uy_q * s2_uy_q;
  end

  // ---------------- stage 4: radius squared ----------------
  logic        rt_v   [0:32];
  logic        rt_ys  [0:32];
  logic [2:0]  rt_src [0:32];
  logic [31:0] rt_uy  [0:32];
  logic [63:0] rt_n   [0:32];
  logic [32:0] rt_rem [0:32];
  logic [31:0] rt_rt  [0:32];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rt_v[0] <= 1'b0;
    end else begin
      rt_v[0] <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rt_src[0] <= s3_src_q;
    rt_ys[0]  <= s3_ys_q;
    rt_uy[0]  <= s3_uy_q;
    rt_n[0]   <= s3_xx_q + s3_yy_q;
  end

  assign rt_rem[0] = '0;
  assign rt_rt[0]  = '0;

  // ---------------- radius root: one result bit per stage ----------------
  for (genvar k = 0; k < 32; k++) begin : g_root
    logic [34:0] ext, trial;
    logic        fit;

    always_comb begin
      ext   = {rt_rem[k], rt_n[k][63:62]};
      trial = {1'b0, rt_rt[k], 2'b01};
      fit   = ext >= trial;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        rt_v[k+1] <= 1'b0;
      end else begin
        rt_v[k+1] <= rt_v[k];
      end
    end

    always_ff @(posedge clk_i) begin
      rt_src[k+1] <= rt_src[k];
      rt_ys[k+1]  <= rt_ys[k];
      rt_uy[k+1]  <= rt_uy[k];
      rt_n[k+1]   <= {rt_n[k][61:0], 2'b00};
      rt_rem[k+1] <= fit ? 33'(ext - trial) : ext[32:0];
      rt_rt[k+1]  <= {rt_rt[k][30:0], fit};
    end
  end

  // ---------------- divider: q = (2 |y| 2^14 + r) / (2 r) ----------------
  logic        dv_v   [0:15];
  logic        dv_ys  [0:15];
  logic        dv_rz  [0:15];
  logic [2:0]  dv_src [0:15];
  logic [47:0] dv_rem [0:15];
  logic [32:0] dv_d   [0:15];
  logic [14:0] dv_q   [0:15];

  assign dv_v[0]   = rt_v[32];
  assign dv_ys[0]  = rt_ys[32];
  assign dv_rz[0]  = (rt_rt[32] == '0);
  assign dv_src[0] = rt_src[32];
  assign dv_rem[0] = {1'b0, rt_uy[32], 15'd0} + {16'd0, rt_rt[32]};
  assign dv_d[0]   = {rt_rt[32], 1'b0};
  assign dv_q[0]   = '0;

  for (genvar k = 0; k < 15; k++) begin : g_div
    logic [47:0] sub;
    logic        fit;

    always_comb begin
      sub = {15'd0, dv_d[k]} << (14 - k);
      fit = dv_rem[k] >= sub;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v[k+1] <= 1'b0;
      end else begin
        dv_v[k+1] <= dv_v[k];
      end
    end

    always_ff @(posedge clk_i) begin
      dv_src[k+1] <= dv_src[k];
      dv_ys[k+1]  <= dv_ys[k];
      dv_rz[k+1]  <= dv_rz[k];
      dv_d[k+1]   <= dv_d[k];
      dv_rem[k+1] <= fit ? dv_rem[k] - sub : dv_rem[k];
      dv_q[k+1]   <= {dv_q[k][13:0], fit};
    end
  end

  // ---------------- pan and center weight ----------------
  logic [15:0] qc, pan_w, dist_w;
  logic [16:0] two_pan;
  logic        pn_v_q;
  logic [15:0] pn_pan_q;
  gain_side_t  pn_side_q;

  always_comb begin
    qc = ({1'b0, dv_q[15]} > HALF_Q15) ? HALF_Q15 : {1'b0, dv_q[15]};
    if (dv_rz[15])      pan_w = HALF_Q15;
    else if (dv_ys[15]) pan_w = HALF_Q15 - qc;
    else                pan_w = HALF_Q15 + qc;
    two_pan = {pan_w, 1'b0};
    dist_w  = (two_pan >= {1'b0, UNITY_Q15}) ? 16'(two_pan - {1'b0, UNITY_Q15})
                                            : 16'({1'b0, UNITY_Q15} - two_pan);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pn_v_q <= 1'b0;
    end else begin
      pn_v_q <= dv_v[15];
    end
  end

  always_ff @(posedge clk_i) begin
    pn_pan_q        <= pan_w;
    pn_side_q.src   <= dv_src[15];
    pn_side_q.tri_w <= UNITY_Q15 - dist_w;
  end

  // ---------------- gain roots ----------------
  logic        gn_v;
  logic [15:0] gn_left, gn_right;
  gain_side_t  gn_side;

  cpp_gain_sqrt u_gain_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (pn_v_q),
    .pan_i   (pn_pan_q),
    .side_i  (pn_side_q),
    .valid_o (gn_v),
    .left_o  (gn_left),
    .right_o (gn_right),
    .side_o  (gn_side)
  );

  // ---------------- output word ----------------
  logic [31:0] mid_prod;
  logic [15:0] left_d, right_d, mid_d, sub_d;
  logic        valid_q;
  logic [15:0] left_q, right_q, mid_q, sub_q;

  always_comb begin
    mid_prod = center_q * gn_side.tri_w + 32'(HALF_Q15);
    left_d   = '0;
    right_d  = '0;
    mid_d    = '0;
    sub_d    = '0;
    if (dest_q == 4'd0) begin
      // no destination: all zero
    end else if (dest_q == 4'd1 || gn_side.src == 3'd0) begin
      left_d = UNITY_Q15;
    end else if (gn_side.src == 3'd1) begin
      right_d = UNITY_Q15;
    end else begin
      left_d  = gn_left;
      right_d = gn_right;
      if (dest_q > 4'd2) mid_d = mid_prod[30:15];
      if (dest_q > 4'd3) sub_d = lfe_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= gn_v;
    end
  end

  always_ff @(posedge clk_i) begin
    left_q  <= left_d;
    right_q <= right_d;
    mid_q   <= mid_d;
    sub_q   <= sub_d;
  end

  assign valid_o      = valid_q;
  assign left_gain_o  = left_q;
  assign right_gain_o = right_q;
  assign mid_gain_o   = mid_q;
  assign sub_gain_o   = sub_q;

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb: self-checking bench of the constant-power pan gain generator
// Feeds source rows through a queue-fed driver, predicts each gain word with
// a fixed-point model of the pan law and checks every strobed result word.
// ----------------------------------------------------------------------------
module tb;
  import cpp_pkg::*;

  localparam int LATENCY   = 70;
  localparam int CYCLE_CAP = 400000;

  typedef struct packed {
    logic [2:0]         src;
    logic signed [31:0] px, py, pz;
    logic signed [15:0] fx, fy, fz, sx, sy, sz;
  } src_row_t;

  typedef struct packed {
    logic [15:0] left, right, mid, sub;
  } gain_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = CFG_DEST_COUNT;
  logic [15:0] cfg_data_i = '0;
  logic [2:0] src_channel_i = '0;
  logic signed [31:0] pos_x_i = '0, pos_y_i = '0, pos_z_i = '0;
  logic signed [15:0] fwd_ax_i = '0, fwd_ay_i = '0, fwd_az_i = '0;
  logic signed [15:0] side_ax_i = '0, side_ay_i = '0, side_az_i = '0;
  logic valid_o;
  logic [15:0] left_gain_o, right_gain_o, mid_gain_o, sub_gain_o;

  constant_power_pan_gains_top dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // predictor copy of the registers
  logic [3:0]  dest_cnt = 4'd2;
  logic [15:0] center_lvl = '0;
  logic [15:0] lfe_lvl = '0;

  src_row_t  pending_rows[$];
  gain_row_t expected_gains[$];
  int send_idle_pct = 16;
  int mismatches = 0;
  int words_checked = 0;
  int cycles = 0;
  bit hold_sender = 1'b0;

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned round_sqrt(longint unsigned n);
    longint unsigned s;
    s = int_sqrt(n);
    return (n - s * s > s) ? s + 1 : s;
  endfunction

  function automatic longint axis_dot(src_row_t r, bit use_side);
    longint sum, q;
    if (use_side)
      sum = longint'(r.px) * r.sx + longint'(r.py) * r.sy + longint'(r.pz) * r.sz;
    else
      sum = longint'(r.px) * r.fx + longint'(r.py) * r.fy + longint'(r.pz) * r.fz;
    q = sum >>> 14;  // floor toward minus infinity
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q;
  endfunction

  function automatic gain_row_t pan_gains(src_row_t r);
    gain_row_t g;
    longint x, y;
    longint unsigned ux, uy, rad, q, pan, d;
    g = '0;
    if (dest_cnt == 0) return g;
    if (dest_cnt == 1 || r.src == 0) begin
      g.left = UNITY_Q15;
      return g;
    end
    if (r.src == 1) begin
      g.right = UNITY_Q15;
      return g;
    end
    x = axis_dot(r, 1'b0);
    y = axis_dot(r, 1'b1);
    ux = (x < 0) ? -x : x;
    uy = (y < 0) ? -y : y;
    rad = int_sqrt(ux * ux + uy * uy);
    if (rad == 0) pan = 16384;
    else begin
      q = (2 * uy * 16384 + rad) / (2 * rad);
      if (q > 16384) q = 16384;
      pan = (y < 0) ? 16384 - q : 16384 + q;
    end
    g.left = 16'(round_sqrt((32768 - pan) * 32768));
    g.right = 16'(round_sqrt(pan * 32768));
    if (dest_cnt > 2) begin
      d = (2 * pan >= 32768) ? 2 * pan - 32768 : 32768 - 2 * pan;
      g.mid = 16'((longint'(center_lvl) * (32768 - d) + 16384) >> 15);
    end
    if (dest_cnt > 3) g.sub = lfe_lvl;
    return g;
  endfunction

  // driver: start stays high across back-to-back words
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycles);
      $display("TB_ERROR");
      $finish;
    end
    if (start && !busy) expected_gains.push_back(pan_gains({src_channel_i, pos_x_i,
      pos_y_i, pos_z_i, fwd_ax_i, fwd_ay_i, fwd_az_i, side_ax_i, side_ay_i, side_az_i}));
    if (rst_ni && !hold_sender && pending_rows.size() > 0 &&
        $urandom_range(99) >= send_idle_pct && !(start && busy)) begin
      src_row_t r;
      r = pending_rows.pop_front();
      start <= 1'b1;
      {src_channel_i, pos_x_i, pos_y_i, pos_z_i, fwd_ax_i, fwd_ay_i, fwd_az_i,
       side_ax_i, side_ay_i, side_az_i} <= r;
    end else if (!(start && busy)) begin
      start <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (valid_o) begin
      gain_row_t want;
      if (expected_gains.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected gain word at cycle %0d", cycles);
      end else begin
        want = expected_gains.pop_front();
        words_checked++;
        if (want != {left_gain_o, right_gain_o, mid_gain_o, sub_gain_o}) begin
          mismatches++;
          if (mismatches <= 10)
            $display("gain mismatch: want L%0d R%0d C%0d S%0d got L%0d R%0d C%0d S%0d",
              want.left, want.right, want.mid, want.sub,
              left_gain_o, right_gain_o, mid_gain_o, sub_gain_o);
        end
      end
    end
  end

  function automatic logic signed [15:0] rand_axis();
    case ($urandom_range(5))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'($urandom);
      default: return 16'($signed($urandom_range(32768)) - 16384);
    endcase
  endfunction

  function automatic logic signed [31:0] rand_pos();
    case ($urandom_range(5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'($signed($urandom_range(2000000)) - 1000000);
      default: return 32'($urandom);
    endcase
  endfunction

  function automatic src_row_t rand_row();
    src_row_t r;
    r.src = ($urandom_range(3) == 0) ? 3'($urandom_range(1)) : 3'($urandom_range(7));
    r.px = rand_pos(); r.py = rand_pos(); r.pz = rand_pos();
    r.fx = rand_axis(); r.fy = rand_axis(); r.fz = rand_axis();
    r.sx = rand_axis(); r.sy = rand_axis(); r.sz = rand_axis();
    return r;
  endfunction

  // let the queue empty, then hold the sender until every word is back
  task automatic drain();
    while (pending_rows.size() > 0)
      @(posedge clk_i);
    hold_sender = 1'b1;
    while (start || expected_gains.size() > 0)
      @(posedge clk_i);
    repeat (LATENCY + 5) @(posedge clk_i);
    hold_sender = 1'b0;
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [15:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_DEST_COUNT: dest_cnt = val[3:0];
      CFG_CENTER:     center_lvl = val;
      CFG_LFE:        lfe_lvl = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  initial begin
    src_row_t r;
    int ph;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed rows at reset settings and at full four-channel settings
    for (int s = 0; s < 2; s++) begin
      for (int c = 0; c < 8; c++) begin
        r = '0;
        r.src = 3'(c);
        r.px = 32'sd65536; r.py = 32'sd65536 * c - 32'sd200000;
        r.fx = 16'sd16384; r.sy = 16'sd16384;
        pending_rows.push_back(r);
      end
      r = '0; r.src = 3'd5; pending_rows.push_back(r);  // zero radius
      r.px = 32'h7fffffff; r.py = 32'h80000000; r.pz = 32'h7fffffff;
      r.fx = 16'h7fff; r.fy = 16'h8000; r.fz = 16'h7fff;
      r.sx = 16'h8000; r.sy = 16'h7fff; r.sz = 16'h8000;
      pending_rows.push_back(r);                        // saturated projections
      r.fx = 16'sd0; r.fy = 16'sd0; r.fz = 16'sd0;
      pending_rows.push_back(r);                        // pure side, hard pan
      drain();
      write_reg(CFG_DEST_COUNT, 16'd4);
      write_reg(CFG_CENTER, 16'd32768);
      write_reg(CFG_LFE, 16'd32768);
    end
    for (ph = 0; ph < 9; ph++) begin
      send_idle_pct = (ph < 3) ? 16 : (ph < 6) ? 61 : 0;
      write_reg(CFG_DEST_COUNT, (ph == 0) ? 16'd0 : (ph == 1) ? 16'd1 :
                (ph == 8) ? 16'hf : 16'($urandom_range(8)));
      write_reg(CFG_CENTER, (ph == 2) ? 16'hffff : (ph == 3) ? 16'd0 :
                16'($urandom_range(32768)));
      write_reg(CFG_LFE, (ph == 4) ? 16'hffff : 16'($urandom));
      for (int i = 0; i < 95; i++) pending_rows.push_back(rand_row());
      drain();  // sender waits for every outstanding word
    end
    $display("checked %0d gain words over 9 register settings plus directed rows",
      words_checked);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
